// File: rtl/chtp_pkg.sv
// ----------------------------------------------------------------------------
// chtp_pkg
// Shared types, sizes and codes for the coordinate hash table probe unit.
// ----------------------------------------------------------------------------
package chtp_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int COORD_W     = 28;
  localparam int HASH_W      = 32;
  localparam int LIMIT_W     = 8;
  localparam int OUT_SLOT_W  = 8;

  localparam logic [7:0] LIMIT_RESET = 8'd192;

  localparam logic [HASH_W-1:0] HASH_MUL_X = 32'h9E3779B1;
  localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'h85EBCA77;
  localparam logic [HASH_W-1:0] HASH_MUL_Z = 32'hC2B2AE3D;

  // opcodes
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_ABSENT   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } chtp_key_t;

  localparam int KEY_W = $bits(chtp_key_t);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_HASH     = 8'b0000_0010,
    S_PROBE    = 8'b0000_0100,
    S_CMP      = 8'b0000_1000,
    S_DEL_NEXT = 8'b0001_0000,
    S_DEL_RD   = 8'b0010_0000,
    S_DEL_HASH = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } chtp_state_t;

endpackage

// File: rtl/chtp_ram.sv
// ----------------------------------------------------------------------------
// chtp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/chtp_hash.sv
// ----------------------------------------------------------------------------
// chtp_hash
// Iterative key hash: one shared 32x32 multiplier, one coordinate per cycle,
// products xor-folded into an accumulator. Home slot valid on done.
// ----------------------------------------------------------------------------
module chtp_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  chtp_pkg::chtp_key_t       key,
  output logic                      done,
  output logic [chtp_pkg::SLOT_W-1:0] home
);
  import chtp_pkg::*;

  chtp_key_t         key_r, key_nxt;
  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  logic [COORD_W-1:0] coord;
  logic [HASH_W-1:0]  mul_a;
  logic [HASH_W-1:0]  mul_b;
  logic [HASH_W-1:0]  prod;

  always_comb begin
    case (step_r)
      2'd0: begin
        coord = key_r.x;
        mul_b = HASH_MUL_X;
      end
      2'd1: begin
        coord = key_r.y;
        mul_b = HASH_MUL_Y;
      end
      default: begin
        coord = key_r.z;
        mul_b = HASH_MUL_Z;
      end
    endcase
  end

  // sign extend to 32 bits, keep low word of the product
  assign mul_a = {{(HASH_W-COORD_W){coord[COORD_W-1]}}, coord};
  assign prod  = mul_a * mul_b;

  always_comb begin
    key_nxt  = key_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      key_nxt  = key;
      acc_nxt  = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      acc_nxt  = acc_r ^ prod;
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd2) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    key_r <= key_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign home = acc_r[SLOT_W-1:0];

endmodule

// File: rtl/coord_hash_table_probe_unit.sv
// ----------------------------------------------------------------------------
// coord_hash_table_probe_unit
// Open-addressing hash table keyed by a signed 3D coordinate, linear probing,
// find / find-or-insert / remove with backward-shift deletion.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per operation (opcode and key), taken only while the
//           sequencer is idle.
//   out_* : one beat per operation (status, slot, removed), held in an
//           output register until taken.
//   cfg_* : entry limit write, only while no operation is in flight.
// Sequence: accept, then the hash (shared multiplier, one coordinate per
//   cycle), then for each slot probed a key store read then a compare,
//   then the output register. A remove then steps through each slot of
//   the following cluster, reading and rehashing every occupied slot
//   through the same unit.
// Throughput: one operation at a time; the next beat is taken as soon as the
//   sequencer returns to idle, even while the previous result still waits.
// Reset: slot valid bits and entry count clear at once, limit returns to
//   192; the key store is not cleared. If the receiver stalls, a finished
//   operation waits in its response state until the output register frees.
// ----------------------------------------------------------------------------
module coord_hash_table_probe_unit (
  input  logic        clk,
  input  logic        rst_n,
  // opcode[1:0], key_x[29:2], key_y[57:30], key_z[85:58], zero pad [87:86]
  input  logic [87:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status[1:0], slot[9:2], removed[10], zero pad [15:11]
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import chtp_pkg::*;

  chtp_state_t state_r, state_nxt;

  logic [1:0]             op_r, op_nxt;
  chtp_key_t              key_r, key_nxt;
  chtp_key_t              mv_r, mv_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]      hole_r, hole_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [TABLE_SLOTS-1:0] used_r, used_nxt;
  logic [LIMIT_W-1:0]     limit_r;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic                   res_removed_r, res_removed_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [15:0]            out_data_r, out_data_nxt;

  logic              accept;
  chtp_key_t         in_key;
  logic [SLOT_W-1:0] idx_inc;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  chtp_key_t         ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  chtp_key_t         ram_rdata;
  logic              hash_start;
  chtp_key_t         hash_key;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_home;
  logic              stays;
  logic              walk_over;
  logic              at_limit;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_key.x  = in_tdata[29:2];
  assign in_key.y  = in_tdata[57:30];
  assign in_key.z  = in_tdata[85:58];
  assign idx_inc   = idx_r + 1'b1;
  assign walk_over = (n_r == CNT_W'(TABLE_SLOTS));
  assign at_limit  = (count_r >= CNT_W'(limit_r));

  assign ram_raddr  = (state_r == S_DEL_NEXT) ? idx_inc : idx_r;
  assign hash_start = accept || (state_r == S_DEL_RD);
  assign hash_key   = (state_r == S_IDLE) ? in_key : ram_rdata;

  // entry keeps its place if its home lies cyclically in (hole, j]
  always_comb begin
    if (hole_r <= idx_r) begin
      stays = (hole_r < hash_home) && (hash_home <= idx_r);
    end else begin
      stays = (hole_r < hash_home) || (hash_home <= idx_r);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    mv_nxt          = mv_r;
    idx_nxt         = idx_r;
    hole_nxt        = hole_r;
    n_nxt           = n_r;
    count_nxt       = count_r;
    used_nxt        = used_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = key_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt          = in_tdata[1:0];
          key_nxt         = in_key;
          res_status_nxt  = ST_ABSENT;
          res_slot_nxt    = '0;
          res_removed_nxt = 1'b0;
          state_nxt       = S_HASH;
        end
      end

      S_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_home;
          n_nxt     = '0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        if (walk_over || !used_r[idx_r]) begin
          state_nxt = S_RESP;
          if (op_r == OP_INSERT) begin
            if (walk_over || at_limit) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we          = 1'b1;
              used_nxt[idx_r] = 1'b1;
              count_nxt       = count_r + 1'b1;
              res_status_nxt  = ST_INSERTED;
              res_slot_nxt    = idx_r;
            end
          end
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        if (ram_rdata == key_r) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = idx_r;
          if (op_r == OP_REMOVE) begin
            res_removed_nxt = 1'b1;
            hole_nxt        = idx_r;
            used_nxt[idx_r] = 1'b0;
            n_nxt           = '0;
            state_nxt       = S_DEL_NEXT;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          idx_nxt   = idx_inc;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_PROBE;
        end
      end

      S_DEL_NEXT: begin
        if (walk_over || !used_r[idx_inc]) begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_inc;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_DEL_RD;
        end
      end

      S_DEL_RD: begin
        mv_nxt    = ram_rdata;
        state_nxt = S_DEL_HASH;
      end

      S_DEL_HASH: begin
        if (hash_done) begin
          if (!stays) begin
            // shift the entry back into the hole
            ram_we           = 1'b1;
            ram_waddr        = hole_r;
            ram_wdata        = mv_r;
            used_nxt[hole_r] = 1'b1;
            used_nxt[idx_r]  = 1'b0;
            hole_nxt         = idx_r;
          end
          state_nxt = S_DEL_NEXT;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, res_removed_r, OUT_SLOT_W'(res_slot_r), res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    mv_r          <= mv_nxt;
    idx_r         <= idx_nxt;
    hole_r        <= hole_nxt;
    n_r           <= n_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_removed_r <= res_removed_nxt;
    out_data_r    <= out_data_nxt;
  end

  chtp_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .home  (hash_home)
  );

  chtp_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sim/coord_hash_table_probe_unit_test.sv
// ----------------------------------------------------------------------------
// coord_hash_table_probe_unit_test
// Self-checking bench for the coordinate hash table probe unit. A driver
// takes operations from a queue and presents them as input beats. A
// table model beside it works out the status, slot and removed flag that
// each accepted beat should give. A monitor checks every result beat
// against the oldest prediction. Directed cases cover the edge coordinates,
// every opcode and a wrapping collision cluster taken apart by removal.
// Random phases then run the table at several entry limits, the extremes
// among them, and fill it to the limit and empty it again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coord_hash_table_probe_unit_test;
  import chtp_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RST_CYCLES     = 8;
  localparam int IDLE_PCT       = 31;
  localparam int SETTLE_CYCLES  = 32;
  localparam int POOL_SIZE      = 300;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 5_000_000;

  // the unit treats the unused opcode as a find
  localparam logic [1:0] OP_ALIAS_FIND = 2'd3;

  localparam logic [COORD_W-1:0] C_MAX  = 28'h7FF_FFFF;
  localparam logic [COORD_W-1:0] C_MIN  = 28'h800_0000;
  localparam logic [COORD_W-1:0] C_NEG1 = 28'hFFF_FFFF;
  localparam logic [COORD_W-1:0] C_ONE  = 28'h000_0001;
  localparam logic [COORD_W-1:0] C_ZERO = 28'h000_0000;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } coord_t;

  typedef struct {
    logic [1:0] op;
    coord_t     key;
  } probe_req_t;

  typedef struct {
    logic [1:0]            status;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  removed;
  } probe_resp_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [87:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  // table model
  logic               tbl_used [TABLE_SLOTS];
  logic [COORD_W-1:0] tbl_x    [TABLE_SLOTS];
  logic [COORD_W-1:0] tbl_y    [TABLE_SLOTS];
  logic [COORD_W-1:0] tbl_z    [TABLE_SLOTS];
  int unsigned        tbl_count;
  logic [LIMIT_W-1:0] tbl_limit;

  probe_req_t  req_q[$];
  probe_resp_t pending_resp_q[$];
  probe_req_t  tx_cur;
  probe_resp_t rx_want;
  coord_t      key_pool [POOL_SIZE];

  int n_pushed     = 0;
  int n_accepted   = 0;
  int n_results    = 0;
  int n_errors     = 0;
  int n_inserted   = 0;
  int n_hits       = 0;
  int n_removed    = 0;
  int n_full       = 0;
  int tx_idle_pct  = IDLE_PCT;
  int rx_idle_pct  = IDLE_PCT;
  int rx_hold_left;
  bit rx_hold_done;
  int mid_limit;

  coord_hash_table_probe_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int unsigned home_slot(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [COORD_W-1:0] z);
    logic [HASH_W-1:0] sx, sy, sz, h;
    sx = {{(HASH_W-COORD_W){x[COORD_W-1]}}, x};
    sy = {{(HASH_W-COORD_W){y[COORD_W-1]}}, y};
    sz = {{(HASH_W-COORD_W){z[COORD_W-1]}}, z};
    h  = (sx * HASH_MUL_X) ^ (sy * HASH_MUL_Y) ^ (sz * HASH_MUL_Z);
    return h % TABLE_SLOTS;
  endfunction

  // hit: slot of the key; miss: first free slot met, or TABLE_SLOTS if none
  function automatic bit locate(input coord_t k, output int unsigned where);
    int unsigned idx;
    idx = home_slot(k.x, k.y, k.z);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!tbl_used[idx]) begin
        where = idx;
        return 1'b0;
      end
      if (tbl_x[idx] == k.x && tbl_y[idx] == k.y && tbl_z[idx] == k.z) begin
        where = idx;
        return 1'b1;
      end
      idx = (idx + 1) % TABLE_SLOTS;
    end
    where = TABLE_SLOTS;
    return 1'b0;
  endfunction

  // backward-shift deletion: pull later cluster members into the hole
  function automatic void shift_delete(int unsigned hole);
    int unsigned j, k;
    bit stays;
    j = hole;
    tbl_used[hole] = 1'b0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      j = (j + 1) % TABLE_SLOTS;
      if (!tbl_used[j]) break;
      k = home_slot(tbl_x[j], tbl_y[j], tbl_z[j]);
      if (hole <= j) stays = (hole < k) && (k <= j);
      else stays = (hole < k) || (k <= j);
      if (!stays) begin
        tbl_x[hole]    = tbl_x[j];
        tbl_y[hole]    = tbl_y[j];
        tbl_z[hole]    = tbl_z[j];
        tbl_used[hole] = 1'b1;
        tbl_used[j]    = 1'b0;
        hole           = j;
      end
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic probe_resp_t probe_table_op(probe_req_t r);
    probe_resp_t p;
    int unsigned where;
    bit hit;
    p.status  = ST_ABSENT;
    p.slot    = '0;
    p.removed = 1'b0;
    hit = locate(r.key, where);
    if (hit) begin
      p.status = ST_FOUND;
      p.slot   = OUT_SLOT_W'(where);
      if (r.op == OP_REMOVE) begin
        shift_delete(where);
        p.removed = 1'b1;
        n_removed++;
      end else begin
        n_hits++;
      end
    end else if (r.op == OP_INSERT) begin
      if (tbl_count >= tbl_limit || where >= TABLE_SLOTS) begin
        p.status = ST_FULL;
        n_full++;
      end else begin
        tbl_used[where] = 1'b1;
        tbl_x[where]    = r.key.x;
        tbl_y[where]    = r.key.y;
        tbl_z[where]    = r.key.z;
        tbl_count++;
        p.status = ST_INSERTED;
        p.slot   = OUT_SLOT_W'(where);
        n_inserted++;
      end
    end
    return p;
  endfunction

  function automatic coord_t random_key();
    coord_t k;
    k.x = COORD_W'($urandom());
    k.y = COORD_W'($urandom());
    k.z = COORD_W'($urandom());
    return k;
  endfunction

  function automatic coord_t key_with_home(int unsigned home);
    coord_t k;
    k = random_key();
    while (home_slot(k.x, k.y, k.z) != home) k = random_key();
    return k;
  endfunction

  task automatic push_op(logic [1:0] op, coord_t k);
    probe_req_t r;
    r.op  = op;
    r.key = k;
    req_q.push_back(r);
    n_pushed++;
  endtask

  task automatic push_random(int count, int lo, int hi);
    int roll;
    logic [1:0] op;
    coord_t k;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) op = OP_INSERT;
      else if (roll < 70) op = OP_FIND;
      else if (roll < 95) op = OP_REMOVE;
      else op = OP_ALIAS_FIND;
      // mostly known keys so that hits and removals happen, some fresh noise
      if ($urandom_range(99) < 15) k = random_key();
      else k = key_pool[$urandom_range(hi, lo)];
      push_op(op, k);
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || pending_resp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tbl_limit  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain_table();
    coord_t keys[$];
    wait_idle();
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (tbl_used[i]) keys.push_back('{tbl_x[i], tbl_y[i], tbl_z[i]});
    foreach (keys[i]) push_op(OP_REMOVE, keys[i]);
  endtask

  // driver: the current beat stays put until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        pending_resp_q.push_back(probe_table_op(tx_cur));
        n_accepted++;
      end
      if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_cur = req_q.pop_front();
        in_tdata  <= {2'b00, tx_cur.key.z, tx_cur.key.y, tx_cur.key.x, tx_cur.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once, so the unit backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
      rx_hold_done <= 1'b0;
    end else if (!rx_hold_done && n_results >= HOLD_AT_RESULT) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_resp_q.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, got %h",
                   $time, out_tdata);
          n_errors++;
        end else begin
          rx_want = pending_resp_q.pop_front();
          if (out_tdata[1:0] !== rx_want.status) begin
            $display("%0t: status expected %0d got %0d", $time, rx_want.status, out_tdata[1:0]);
            n_errors++;
          end
          if (out_tdata[9:2] !== rx_want.slot) begin
            $display("%0t: slot expected %0d got %0d", $time, rx_want.slot, out_tdata[9:2]);
            n_errors++;
          end
          if (out_tdata[10] !== rx_want.removed) begin
            $display("%0t: removed expected %0b got %0b", $time, rx_want.removed, out_tdata[10]);
            n_errors++;
          end
          if (out_tdata[15:11] !== 5'd0) begin
            $display("%0t: pad expected 0 got %b", $time, out_tdata[15:11]);
            n_errors++;
          end
        end
      end
      out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    coord_t ka, kb, kc, kd;
    for (int i = 0; i < TABLE_SLOTS; i++) tbl_used[i] = 1'b0;
    tbl_count = 0;
    tbl_limit = LIMIT_RESET;
    key_pool[0] = '{C_ZERO, C_ZERO, C_ZERO};
    key_pool[1] = '{C_MAX, C_MAX, C_MAX};
    key_pool[2] = '{C_MIN, C_MIN, C_MIN};
    key_pool[3] = '{C_NEG1, C_NEG1, C_NEG1};
    key_pool[4] = '{C_MIN, C_MAX, C_NEG1};
    key_pool[5] = '{C_MAX, C_MIN, C_ONE};
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = random_key();
    // three keys homed on the last slot and one on slot 0: a cluster that wraps
    ka = key_with_home(TABLE_SLOTS - 1);
    kb = key_with_home(TABLE_SLOTS - 1);
    kc = key_with_home(TABLE_SLOTS - 1);
    kd = key_with_home(0);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    push_op(OP_FIND, key_pool[0]);
    push_op(OP_REMOVE, key_pool[0]);
    push_op(OP_INSERT, key_pool[0]);
    push_op(OP_INSERT, key_pool[0]);
    push_op(OP_FIND, key_pool[0]);
    push_op(OP_ALIAS_FIND, key_pool[0]);
    push_op(OP_REMOVE, key_pool[0]);
    push_op(OP_FIND, key_pool[0]);
    for (int i = 1; i < 6; i++) push_op(OP_INSERT, key_pool[i]);
    push_op(OP_INSERT, ka);
    push_op(OP_INSERT, kb);
    push_op(OP_INSERT, kd);
    push_op(OP_INSERT, kc);
    push_op(OP_REMOVE, ka);
    push_op(OP_FIND, kc);
    push_op(OP_FIND, kd);
    push_op(OP_REMOVE, kd);
    push_op(OP_REMOVE, kc);
    push_op(OP_FIND, kb);

    push_random(450, 0, 219);
    drain_table();

    write_limit(8'd1);
    push_random(120, 0, 15);
    write_limit(8'd0);
    push_random(60, 0, 15);

    // fill up to the largest limit, then work on a nearly full table
    write_limit(8'd255);
    for (int i = 0; i < 280; i++) push_op(OP_INSERT, key_pool[i]);
    push_random(80, 0, POOL_SIZE - 1);
    mid_limit = $urandom_range(191, 2);
    write_limit(LIMIT_W'(mid_limit));
    push_random(60, 0, POOL_SIZE - 1);
    drain_table();

    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random(250, 0, 219);
    wait_idle();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;

    write_limit(LIMIT_RESET);
    push_random(150, 0, 219);
    wait_idle();

    $display("ran %0d operations at entry limits 192, 1, 0, 255 and %0d, with a full drain twice",
             n_accepted, mid_limit);
    $display("%0d inserted, %0d hits, %0d removed, %0d refused as full, %0d mismatches",
             n_inserted, n_hits, n_removed, n_full, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
